/* sv/lkvc_pkg.sv */
// shared types and constants for the lru key value cache
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_MAX   = 64;
    localparam int VALUE_MAX = 64;
    localparam int RANK_MAX  = 8;
    localparam int CNT_MAX   = 9;
    localparam int CFG_BITS  = 5;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MODE_HIT   = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_EVICT = 2'd2
    } upd_mode_t;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [63:0] evicted_key;
    } rsp_t;

    // result gathered along the row of cells
    typedef struct packed {
        logic                 hit;
        logic [VALUE_MAX-1:0] data;
        logic [RANK_MAX-1:0]  rank;
        logic                 free_seen;
        logic [KEY_MAX-1:0]   evk;
    } carry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 upd;
        upd_mode_t            mode;
        logic                 wr_key;
        logic                 wr_value;
        logic [CNT_MAX-1:0]   rank_lim;
        logic [RANK_MAX-1:0]  victim_rank;
        logic [KEY_MAX-1:0]   key;
        logic [VALUE_MAX-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/lru_key_value_cache_top.sv */
// lru key value cache: a row of CAPACITY entry cells, a controller and a result register
// a new item is taken only after the previous one has finished its update, set by the gather chain through the cells
// the chain moves one cell a cycle, so a scan waits for it to pass every cell before the update
// reset clears the valid marks, ranks, entry count and state; the entry limit resets to 16
// no clearing pass after reset: the first item is taken in the first cycle out of reset
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_top #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire lkvc_pkg::req_t                      in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output lkvc_pkg::rsp_t                           out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lkvc_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int RW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [RW-1:0]                   scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [lkvc_pkg::CFG_BITS-1:0]   cfg_reg;
    lkvc_pkg::req_t                  req_reg;
    logic                            out_valid_reg, out_valid_next;
    lkvc_pkg::rsp_t                  out_reg, out_next;

    lkvc_pkg::carry_t                chain [0:CAPACITY];
    lkvc_pkg::carry_t                last;
    lkvc_pkg::cmd_t                  cmd;

    logic [CW-1:0] limit;
    logic          in_xfer;
    logic          out_free;
    logic          free_ok;
    logic          is_insert;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign last      = chain[CAPACITY];
    assign is_insert = (req_reg.op == lkvc_pkg::OP_INSERT);
    assign free_ok   = (count_reg < limit);

    // effective limit, clamped to one .. CAPACITY
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (32'(cfg_reg) > CAPACITY)
        begin
            limit = CW'(CAPACITY);
        end
        else
        begin
            limit = CW'(cfg_reg);
        end
    end

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            lkvc_cell #(
                .CAPACITY   (CAPACITY),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .carry_in  (chain[gi]),
                .carry_out (chain[gi+1])
            );
        end
    endgenerate

    // broadcast to the cells
    always_comb
    begin
        cmd.upd         = (state_reg == ST_UPDATE) && out_free && (last.hit || is_insert);
        cmd.key         = lkvc_pkg::KEY_MAX'(req_reg.key[KEY_BITS-1:0]);
        cmd.value       = lkvc_pkg::VALUE_MAX'(req_reg.value);
        cmd.victim_rank = lkvc_pkg::RANK_MAX'(CW'(count_reg - CW'(1)));
        cmd.wr_value    = is_insert;
        cmd.wr_key      = !last.hit;
        priority if (last.hit)
        begin
            cmd.mode     = lkvc_pkg::MODE_HIT;
            cmd.rank_lim = lkvc_pkg::CNT_MAX'(last.rank);
        end
        else if (free_ok)
        begin
            cmd.mode     = lkvc_pkg::MODE_FREE;
            cmd.rank_lim = lkvc_pkg::CNT_MAX'(count_reg);
        end
        else
        begin
            cmd.mode     = lkvc_pkg::MODE_EVICT;
            cmd.rank_lim = lkvc_pkg::CNT_MAX'(cmd.victim_rank);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + RW'(1);
                if (scan_cnt_reg == RW'(CAPACITY - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next             = ST_IDLE;
                    out_valid_next         = 1'b1;
                    out_next.hit           = last.hit;
                    out_next.read_value    = (last.hit && !is_insert) ? 32'(last.data) : '0;
                    out_next.evicted       = !last.hit && is_insert && !free_ok;
                    out_next.evicted_key   = out_next.evicted ? last.evk : '0;
                    if (!last.hit && is_insert && free_ok)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            cfg_reg       <= lkvc_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_xfer)
        begin
            req_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // entry count never exceeds the row
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // an input transfer starts a scan
    a_xfer_scan : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_SCAN))
        else $error("input transfer did not start a scan");

    // a finished update always presents a result
    a_update_out : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("update without result");

    // a hit never evicts
    a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.hit && out_reg.evicted))
        else $error("hit and eviction together");

endmodule

`default_nettype wire

/* sv/lkvc_cell.sv */
// one cache entry: key, value, valid mark and recency rank, chained to its neighbor
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lkvc_pkg::cmd_t   cmd,
    input  wire lkvc_pkg::carry_t carry_in,
    output lkvc_pkg::carry_t      carry_out
);

    localparam int RW = $clog2(CAPACITY);

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  valid_reg, valid_next;
    logic [RW-1:0]         rank_reg,  rank_next;
    lkvc_pkg::carry_t      carry_reg, carry_next;

    logic match;
    logic first_free;
    logic victim;
    logic target;

    assign match      = valid_reg && (key_reg == cmd.key[KEY_BITS-1:0]);
    assign first_free = !valid_reg && !carry_in.free_seen;
    assign victim     = valid_reg && (lkvc_pkg::RANK_MAX'(rank_reg) == cmd.victim_rank);

    always_comb
    begin
        carry_next.hit       = carry_in.hit | match;
        carry_next.data      = carry_in.data |
                               (match ? lkvc_pkg::VALUE_MAX'(value_reg) : '0);
        carry_next.rank      = carry_in.rank |
                               (match ? lkvc_pkg::RANK_MAX'(rank_reg) : '0);
        carry_next.free_seen = carry_in.free_seen | !valid_reg;
        carry_next.evk       = carry_in.evk |
                               (victim ? lkvc_pkg::KEY_MAX'(key_reg) : '0);
    end

    always_comb
    begin
        unique case (cmd.mode)
            lkvc_pkg::MODE_HIT:   target = match;
            lkvc_pkg::MODE_FREE:  target = first_free;
            lkvc_pkg::MODE_EVICT: target = victim;
            default:              target = 1'b0;
        endcase
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.upd)
        begin
            if (target)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                if (cmd.wr_key)
                begin
                    key_next = cmd.key[KEY_BITS-1:0];
                end
                if (cmd.wr_value)
                begin
                    value_next = cmd.value[VALUE_BITS-1:0];
                end
            end
            else if (valid_reg && (lkvc_pkg::CNT_MAX'(rank_reg) < cmd.rank_lim))
            begin
                rank_next = rank_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for the lru key value cache with a cycle-free cache predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH          = 16;
    localparam int POOL_SIZE      = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 4;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_stall;
    lkvc_pkg::req_t                in_data    = '0;
    logic                          out_valid;
    wire logic                     out_stall;
    lkvc_pkg::rsp_t                out_data;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [lkvc_pkg::CFG_BITS-1:0] cfg_data   = '0;

    logic        rx_stall     = 1'b1;
    logic        hold_stall   = 1'b0;
    logic        hold_request = 1'b0;
    int unsigned hold_cycles  = 0;
    int unsigned tx_max_gap   = 5;
    int unsigned rx_max_gap   = 5;
    int unsigned err_count    = 0;

    // predictor state
    logic [63:0]                   slot_key [DEPTH];
    logic [31:0]                   slot_val [DEPTH];
    logic                          slot_vld [DEPTH];
    int unsigned                   slot_age [DEPTH];
    logic [lkvc_pkg::CFG_BITS-1:0] limit_reg;

    logic [63:0]    key_pool [POOL_SIZE];
    lkvc_pkg::rsp_t expect_q [$];

    assign out_stall = rx_stall | hold_stall;

    lru_key_value_cache_top #(
        .CAPACITY   (DEPTH),
        .KEY_BITS   (64),
        .VALUE_BITS (32)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void promote(input int e);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_vld[i] && i != e && slot_age[i] < slot_age[e])
                slot_age[i]++;
        end
        slot_age[e] = 0;
    endfunction

    function automatic lkvc_pkg::rsp_t cache_predict(input lkvc_pkg::req_t r);
        lkvc_pkg::rsp_t res;
        int   found;
        int   free_slot;
        int   victim;
        int   used;
        int   cap;
        res       = '0;
        found     = -1;
        free_slot = -1;
        victim    = -1;
        used      = 0;
        cap       = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_vld[i])
            begin
                used++;
                if (found < 0 && slot_key[i] == r.key)
                    found = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            promote(found);
            if (r.op == lkvc_pkg::OP_LOOKUP)
                res.read_value = slot_val[found];
            else
                slot_val[found] = r.value;
        end
        else if (r.op == lkvc_pkg::OP_INSERT)
        begin
            if (used < cap && free_slot >= 0)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_vld[i])
                        slot_age[i]++;
                end
                slot_vld[free_slot] = 1'b1;
                slot_age[free_slot] = 0;
                slot_key[free_slot] = r.key;
                slot_val[free_slot] = r.value;
            end
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_vld[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                end
                if (victim >= 0)
                begin
                    res.evicted     = 1'b1;
                    res.evicted_key = slot_key[victim];
                    promote(victim);
                    slot_key[victim] = r.key;
                    slot_val[victim] = r.value;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] next_key();
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
        err_count++;
    endtask

    task automatic check_result(input lkvc_pkg::rsp_t seen);
        lkvc_pkg::rsp_t want;
        if (expect_q.size() == 0)
        begin
            report_mismatch("result with nothing pending", seen.evicted_key, 64'h0);
        end
        else
        begin
            want = expect_q.pop_front();
            if (seen.hit !== want.hit)
                report_mismatch("hit", 64'(seen.hit), 64'(want.hit));
            if (seen.read_value !== want.read_value)
                report_mismatch("read_value", 64'(seen.read_value), 64'(want.read_value));
            if (seen.evicted !== want.evicted)
                report_mismatch("evicted", 64'(seen.evicted), 64'(want.evicted));
            if (seen.evicted_key !== want.evicted_key)
                report_mismatch("evicted_key", seen.evicted_key, want.evicted_key);
        end
    endtask

    task automatic send_request(input lkvc_pkg::op_t op, input logic [63:0] key,
                                input logic [31:0] value);
        int unsigned    gap;
        logic           taken;
        lkvc_pkg::req_t r;
        lkvc_pkg::rsp_t pred;
        r.op    = op;
        r.key   = key;
        r.value = value;
        gap     = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pred     = cache_predict(r);
        expect_q = {expect_q, pred};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [lkvc_pkg::CFG_BITS-1:0] v);
        logic taken;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    task automatic test_empty_lookup();
        send_request(lkvc_pkg::OP_LOOKUP, 64'h0, 32'h0);
        send_request(lkvc_pkg::OP_LOOKUP, '1, '1);
    endtask

    task automatic test_insert_update();
        send_request(lkvc_pkg::OP_INSERT, '1, '1);
        send_request(lkvc_pkg::OP_INSERT, 64'h0, 32'h0);
        send_request(lkvc_pkg::OP_LOOKUP, '1, 32'h0);
        send_request(lkvc_pkg::OP_LOOKUP, 64'h0, '1);
        send_request(lkvc_pkg::OP_INSERT, '1, 32'h5a5a_a5a5);
        send_request(lkvc_pkg::OP_LOOKUP, '1, 32'h0);
    endtask

    task automatic test_limit_extremes();
        // limit of zero acts as one, and two entries are already in use
        write_limit(5'd0);
        send_request(lkvc_pkg::OP_INSERT, 64'h1111_0000_0000_1111, 32'h8000_0001);
        send_request(lkvc_pkg::OP_INSERT, 64'h2222_0000_0000_2222, 32'h7fff_fffe);
        send_request(lkvc_pkg::OP_LOOKUP, 64'h2222_0000_0000_2222, 32'h0);
        // limit above capacity clamps to capacity
        write_limit(5'd31);
        send_request(lkvc_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 32'h1);
        send_request(lkvc_pkg::OP_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h2);
        send_request(lkvc_pkg::OP_INSERT, 64'h0000_0000_0000_0001, 32'h3);
        // lowered below the number of valid entries
        write_limit(5'd1);
        send_request(lkvc_pkg::OP_INSERT, 64'hdead_beef_0bad_f00d, 32'hcafe_f00d);
        send_request(lkvc_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
        send_request(lkvc_pkg::OP_LOOKUP, 64'hdead_beef_0bad_f00d, 32'h0);
    endtask

    task automatic test_back_pressure();
        write_limit(5'd16);
        tx_max_gap   = 0;
        rx_max_gap   = 0;
        hold_cycles  = 300;
        hold_request = 1'b1;
        for (int n = 0; n < 20; n++)
            send_request(lkvc_pkg::op_t'($urandom_range(0, 1)), next_key(), $urandom);
        wait_drained();
    endtask

    task automatic run_phase(input logic [lkvc_pkg::CFG_BITS-1:0] lim,
                             input int unsigned tx_gap,
                             input int unsigned rx_gap, input int count);
        write_limit(lim);
        tx_max_gap = tx_gap;
        rx_max_gap = rx_gap;
        for (int n = 0; n < count; n++)
            send_request(lkvc_pkg::op_t'($urandom_range(0, 1)), next_key(), $urandom);
    endtask

    task automatic test_random_traffic();
        run_phase(5'd16, 5, 5, 100);
        run_phase(5'd4, 0, 0, 60);
        run_phase(5'd1, 5, 0, 40);
        run_phase(5'd16, 0, 5, 80);
        run_phase(5'd31, 5, 5, 40);
        run_phase(5'd0, 0, 0, 30);
        run_phase(5'($urandom_range(2, 15)), 5, 5, 60);
        run_phase(5'($urandom_range(0, 31)), 3, 3, 60);
    endtask

    initial
    begin : result_monitor
        int unsigned    pause;
        logic           taken;
        lkvc_pkg::rsp_t seen;
        forever
        begin
            pause = $urandom_range(0, rx_max_gap);
            if (pause > 0)
            begin
                rx_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            rx_stall <= 1'b0;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = out_valid && !out_stall;
                seen  = out_data;
                @(posedge clk);
            end
            check_result(seen);
        end
    end

    initial
    begin : long_hold
        forever
        begin
            wait (hold_request);
            @(posedge clk);
            hold_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_stall   <= 1'b0;
            hold_request = 1'b0;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** lru_key_value_cache_top: FAILED **");
        $finish;
    end

    initial
    begin : main
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_vld[i] = 1'b0;
            slot_age[i] = 0;
        end
        limit_reg = lkvc_pkg::CFG_RESET;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_lookup();
        test_insert_update();
        test_limit_extremes();
        test_back_pressure();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("** lru_key_value_cache_top: PASSED **");
        else
            $display("** lru_key_value_cache_top: FAILED **");
        $finish;
    end

endmodule
